// ----- rtl/md_emr_pkg.sv -----
package md_emr_pkg;

	localparam int MAX_PARTICLES = 1024;
	localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
	localparam int ADDR_W = $clog2(MAX_PARTICLES);

	// 1 / (3 * 8.314e-7) in Q16.16
	localparam logic [34:0] TEMP_SCALE = 35'd26275358833;

	localparam logic [1:0] TYPE_NITROGEN = 2'd0;
	localparam logic [1:0] TYPE_OXYGEN   = 2'd1;

	localparam logic [1:0] REG_MASS_NITROGEN  = 2'd0;
	localparam logic [1:0] REG_MASS_OXYGEN    = 2'd1;
	localparam logic [1:0] REG_MASS_NOBLE_GAS = 2'd2;

	typedef logic [4:0] op_t;
	localparam op_t OP_NOP = 5'd0;
	localparam op_t OP_VX2 = 5'd1;
	localparam op_t OP_VY2 = 5'd2;
	localparam op_t OP_VZ2 = 5'd3;
	localparam op_t OP_MVX = 5'd4;
	localparam op_t OP_MVY = 5'd5;
	localparam op_t OP_MVZ = 5'd6;
	localparam op_t OP_MPX = 5'd7;
	localparam op_t OP_MPY = 5'd8;
	localparam op_t OP_MPZ = 5'd9;
	localparam op_t OP_KLO = 5'd10;
	localparam op_t OP_KHI = 5'd11;
	localparam op_t OP_LD  = 5'd12;
	localparam op_t OP_DX2 = 5'd13;
	localparam op_t OP_DY2 = 5'd14;
	localparam op_t OP_DZ2 = 5'd15;
	localparam op_t OP_TLO = 5'd16;
	localparam op_t OP_THI = 5'd17;
	localparam op_t OP_QLO = 5'd18;
	localparam op_t OP_QHI = 5'd19;

	localparam logic [2:0] DIV_COM_X = 3'd0;
	localparam logic [2:0] DIV_COM_Y = 3'd1;
	localparam logic [2:0] DIV_COM_Z = 3'd2;
	localparam logic [2:0] DIV_VCM_X = 3'd3;
	localparam logic [2:0] DIV_VCM_Y = 3'd4;
	localparam logic [2:0] DIV_VCM_Z = 3'd5;
	localparam logic [2:0] DIV_TEMP  = 3'd6;

	typedef struct packed {
		logic [1:0]         particle_type;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic               last;
	} particle_t;

	typedef struct packed {
		logic signed [31:0] com_x;
		logic signed [31:0] com_y;
		logic signed [31:0] com_z;
		logic [62:0]        kinetic_energy;
		logic signed [63:0] momentum_x;
		logic signed [63:0] momentum_y;
		logic signed [63:0] momentum_z;
		logic [62:0]        temperature;
		logic               zero_mass_error;
		logic               overflow;
	} result_t;

	typedef struct packed {
		logic [31:0] mass_nitrogen;
		logic [31:0] mass_oxygen;
		logic [31:0] mass_noble_gas;
	} mass_cfg_t;

	typedef struct packed {
		logic [1:0]  ptype;
		logic [31:0] vz;
		logic [31:0] vy;
		logic [31:0] vx;
	} vel_entry_t;

	typedef struct packed {
		logic       take;
		op_t        op;
		logic       div_start;
		logic [2:0] div_sel;
		logic       idx_clr;
		logic       rd;
		logic       res_load;
		logic       err;
	} ctrl_cmd_t;

	typedef struct packed {
		logic full;
		logic mass_zero;
		logic div_done;
		logic idx_end;
		logic slot_free;
	} dp_stat_t;

	function automatic logic [31:0] mass_of(input mass_cfg_t cfg, input logic [1:0] t);
		logic [31:0] m;
		case (t)
			TYPE_NITROGEN: m = cfg.mass_nitrogen;
			TYPE_OXYGEN:   m = cfg.mass_oxygen;
			default:       m = cfg.mass_noble_gas;
		endcase
		return m;
	endfunction

endpackage

// ----- rtl/md_emr_div.sv -----
module md_emr_div import md_emr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [47:0] divisor,
	output logic [63:0] quotient,
	output logic        done
);

	logic [63:0] q_q;
	logic [47:0] rem_q;
	logic [47:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [48:0] trial;
	logic        fits;

	// one quotient bit a cycle, restoring
	assign trial = {rem_q, q_q[63]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? 48'(trial - {1'b0, dvs_q}) : trial[47:0];
			q_q   <= {q_q[62:0], fits};
		end
	end

	assign quotient = q_q;
	assign done     = done_q;

endmodule

// ----- rtl/md_emr_ctrl.sv -----
module md_emr_ctrl import md_emr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_last,
	output logic      in_ready,
	output ctrl_cmd_t cmd,
	input  dp_stat_t  stat
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_P1   = 4'd1;
	localparam logic [3:0] S_P1D  = 4'd2;
	localparam logic [3:0] S_CHK  = 4'd3;
	localparam logic [3:0] S_DIV  = 4'd4;
	localparam logic [3:0] S_DIVW = 4'd5;
	localparam logic [3:0] S_RD   = 4'd6;
	localparam logic [3:0] S_LD   = 4'd7;
	localparam logic [3:0] S_T    = 4'd8;
	localparam logic [3:0] S_TD   = 4'd9;
	localparam logic [3:0] S_Q    = 4'd10;
	localparam logic [3:0] S_QD   = 4'd11;
	localparam logic [3:0] S_OUT  = 4'd12;

	logic [3:0] state_q;
	logic [3:0] step_q;
	logic [2:0] sel_q;
	logic       last_q;
	logic       err_q;

	function automatic op_t p1_op(input logic [3:0] s);
		op_t o;
		case (s)
			4'd0:    o = OP_VX2;
			4'd1:    o = OP_VY2;
			4'd2:    o = OP_VZ2;
			4'd3:    o = OP_MVX;
			4'd4:    o = OP_MVY;
			4'd5:    o = OP_MVZ;
			4'd6:    o = OP_MPX;
			4'd7:    o = OP_MPY;
			4'd8:    o = OP_MPZ;
			4'd9:    o = OP_KLO;
			4'd10:   o = OP_KHI;
			default: o = OP_NOP;
		endcase
		return o;
	endfunction

	// bubble at step 3 lets the last square land before the weighting
	function automatic op_t t_op(input logic [3:0] s);
		op_t o;
		case (s)
			4'd0:    o = OP_DX2;
			4'd1:    o = OP_DY2;
			4'd2:    o = OP_DZ2;
			4'd4:    o = OP_TLO;
			4'd5:    o = OP_THI;
			default: o = OP_NOP;
		endcase
		return o;
	endfunction

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.div_sel = sel_q;
		cmd.err     = err_q;
		case (state_q)
			S_IDLE: cmd.take = in_valid;
			S_P1:   cmd.op = p1_op(step_q);
			S_CHK:  cmd.idx_clr = 1'b1;
			S_DIV:  cmd.div_start = 1'b1;
			S_RD:   cmd.rd = 1'b1;
			S_LD:   cmd.op = OP_LD;
			S_T:    cmd.op = t_op(step_q);
			S_Q:    cmd.op = (step_q == 4'd0) ? OP_QLO : OP_QHI;
			S_OUT:  cmd.res_load = stat.slot_free;
			default: cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			sel_q   <= '0;
			last_q  <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						last_q <= in_last;
						step_q <= '0;
						if (!stat.full)
							state_q <= S_P1;
						else if (in_last)
							state_q <= S_CHK;
					end
				end
				S_P1: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd10) begin
						step_q  <= '0;
						state_q <= S_P1D;
					end
				end
				S_P1D: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd1) begin
						step_q  <= '0;
						state_q <= last_q ? S_CHK : S_IDLE;
					end
				end
				S_CHK: begin
					sel_q <= DIV_COM_X;
					err_q <= stat.mass_zero;
					state_q <= stat.mass_zero ? S_OUT : S_DIV;
				end
				S_DIV: state_q <= S_DIVW;
				S_DIVW: begin
					if (stat.div_done) begin
						step_q <= '0;
						if (sel_q == DIV_TEMP)
							state_q <= S_Q;
						else if (sel_q == DIV_VCM_Z)
							state_q <= S_RD;
						else begin
							sel_q   <= sel_q + 3'd1;
							state_q <= S_DIV;
						end
					end
				end
				S_RD: state_q <= S_LD;
				S_LD: begin
					step_q  <= '0;
					state_q <= S_T;
				end
				S_T: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd5) begin
						step_q  <= '0;
						state_q <= stat.idx_end ? S_TD : S_RD;
					end
				end
				S_TD: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd1) begin
						sel_q   <= DIV_TEMP;
						state_q <= S_DIV;
					end
				end
				S_Q: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd1) begin
						step_q  <= '0;
						state_q <= S_QD;
					end
				end
				S_QD: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd1)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (stat.slot_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/md_emr_dp.sv -----
module md_emr_dp import md_emr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ctrl_cmd_t cmd,
	output dp_stat_t  stat,
	input  particle_t in_data,
	input  mass_cfg_t mass_cfg,
	input  logic      out_ready,
	output logic      out_valid,
	output result_t   out_data
);

	localparam logic [1:0] TGT_KIN   = 2'd0;
	localparam logic [1:0] TGT_THERM = 2'd1;
	localparam logic [1:0] TGT_TEMP  = 2'd2;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [47:0]      mass_sum_q;
	logic [63:0]      kin_q;
	logic [63:0]      therm_q;
	logic [63:0]      mom_q [3];
	logic [63:0]      wps_q [3];
	logic             ovf_q;

	logic [31:0] m_q;
	logic [32:0] av_q [3];
	logic        sv_q [3];
	logic [32:0] ap_q [3];
	logic        sp_q [3];
	logic [65:0] s_q;
	logic [67:0] w_q;
	logic [63:0] tq_q;
	logic [31:0] com_q [3];
	logic [31:0] vcm_q [3];
	logic [62:0] temp_q;

	logic [67:0] prod_s1;
	op_t         op_s1;
	logic [63:0] wt_s2;
	logic [1:0]  tgt_s2;
	logic        v_s2;

	logic [2:0]  dsel_q;
	logic        dsign_q;
	logic [63:0] div_dvd;
	logic [47:0] div_dvs;
	logic        div_sign;
	logic [63:0] div_q;
	logic        div_done;
	logic [31:0] div_res;

	vel_entry_t mem [MAX_PARTICLES];
	vel_entry_t dout_q;
	logic       wr_en;

	result_t res_q;
	result_t res_next;
	logic    out_valid_q;

	logic [32:0]  mul_a;
	logic [34:0]  mul_b;
	logic [67:0]  mul_p;
	logic [100:0] wide_sum;
	logic [63:0]  wt_next;
	logic [31:0]  m_in;

	function automatic logic [32:0] mag33(input logic [32:0] v);
		return v[32] ? 33'(33'd0 - v) : v;
	endfunction

	function automatic logic [63:0] mag64(input logic [63:0] v);
		return v[63] ? 64'(64'd0 - v) : v;
	endfunction

	function automatic logic [63:0] add_ssat(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		return s[63:0];
	endfunction

	function automatic logic [63:0] add_usat(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

	function automatic logic [63:0] sterm(input logic sgn, input logic [67:0] p);
		return sgn ? 64'(64'd0 - {1'b0, p[62:0]}) : {1'b0, p[62:0]};
	endfunction

	function automatic logic [31:0] sat32(input logic sgn, input logic [63:0] q);
		if (sgn)
			return (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - q);
		return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
	endfunction

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op) inside
			OP_VX2, OP_DX2: begin mul_a = av_q[0]; mul_b = {2'b0, av_q[0]}; end
			OP_VY2, OP_DY2: begin mul_a = av_q[1]; mul_b = {2'b0, av_q[1]}; end
			OP_VZ2, OP_DZ2: begin mul_a = av_q[2]; mul_b = {2'b0, av_q[2]}; end
			OP_MVX: begin mul_a = av_q[0]; mul_b = {3'b0, m_q}; end
			OP_MVY: begin mul_a = av_q[1]; mul_b = {3'b0, m_q}; end
			OP_MVZ: begin mul_a = av_q[2]; mul_b = {3'b0, m_q}; end
			OP_MPX: begin mul_a = ap_q[0]; mul_b = {3'b0, m_q}; end
			OP_MPY: begin mul_a = ap_q[1]; mul_b = {3'b0, m_q}; end
			OP_MPZ: begin mul_a = ap_q[2]; mul_b = {3'b0, m_q}; end
			OP_KLO, OP_TLO: begin mul_a = s_q[32:0]; mul_b = {3'b0, m_q}; end
			OP_KHI, OP_THI: begin mul_a = s_q[65:33]; mul_b = {3'b0, m_q}; end
			OP_QLO: begin mul_a = tq_q[32:0]; mul_b = TEMP_SCALE; end
			OP_QHI: begin mul_a = {2'b0, tq_q[63:33]}; mul_b = TEMP_SCALE; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign mul_p = {35'd0, mul_a} * {33'd0, mul_b};

	// (low + high << 33) >> 16, saturated to 64 bits
	assign wide_sum = {33'd0, w_q} + {prod_s1, 33'd0};
	assign wt_next  = (|wide_sum[100:80]) ? {64{1'b1}} : wide_sum[79:16];

	assign m_in  = mass_of(mass_cfg, in_data.particle_type);
	assign wr_en = cmd.take && !stat.full;

	always_comb begin
		case (cmd.div_sel)
			DIV_COM_X: begin div_dvd = mag64(wps_q[0]); div_sign = wps_q[0][63]; end
			DIV_COM_Y: begin div_dvd = mag64(wps_q[1]); div_sign = wps_q[1][63]; end
			DIV_COM_Z: begin div_dvd = mag64(wps_q[2]); div_sign = wps_q[2][63]; end
			DIV_VCM_X: begin div_dvd = mag64(mom_q[0]); div_sign = mom_q[0][63]; end
			DIV_VCM_Y: begin div_dvd = mag64(mom_q[1]); div_sign = mom_q[1][63]; end
			DIV_VCM_Z: begin div_dvd = mag64(mom_q[2]); div_sign = mom_q[2][63]; end
			default:   begin div_dvd = therm_q; div_sign = 1'b0; end
		endcase
		div_dvs = (cmd.div_sel == DIV_TEMP) ? 48'(count_q) : mass_sum_q;
	end

	md_emr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (div_q),
		.done     (div_done)
	);

	assign div_res = sat32(dsign_q, div_q);

	// result word as loaded into the output register
	always_comb begin
		res_next = '0;
		res_next.overflow = ovf_q;
		if (cmd.err) begin
			res_next.zero_mass_error = 1'b1;
		end else begin
			res_next.com_x          = com_q[0];
			res_next.com_y          = com_q[1];
			res_next.com_z          = com_q[2];
			res_next.kinetic_energy = kin_q[63:1];
			res_next.momentum_x     = mom_q[0];
			res_next.momentum_y     = mom_q[1];
			res_next.momentum_z     = mom_q[2];
			res_next.temperature    = temp_q;
		end
	end

	// velocity and type store
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[count_q[ADDR_W-1:0]] <= {in_data.particle_type, in_data.vel_z,
				in_data.vel_y, in_data.vel_x};
		if (cmd.rd)
			dout_q <= mem[idx_q[ADDR_W-1:0]];
	end

	// running sums and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			mass_sum_q  <= '0;
			kin_q       <= '0;
			therm_q     <= '0;
			ovf_q       <= 1'b0;
			op_s1       <= OP_NOP;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				mom_q[k] <= '0;
				wps_q[k] <= '0;
			end
		end else begin
			op_s1 <= cmd.op;
			v_s2  <= (op_s1 == OP_KHI) || (op_s1 == OP_THI) || (op_s1 == OP_QHI);

			if (cmd.take) begin
				if (stat.full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q    <= count_q + 1'b1;
					mass_sum_q <= mass_sum_q + 48'(m_in);
				end
			end

			if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.rd)
				idx_q <= idx_q + 1'b1;

			case (op_s1)
				OP_MVX: mom_q[0] <= add_ssat(mom_q[0], sterm(sv_q[0], prod_s1));
				OP_MVY: mom_q[1] <= add_ssat(mom_q[1], sterm(sv_q[1], prod_s1));
				OP_MVZ: mom_q[2] <= add_ssat(mom_q[2], sterm(sv_q[2], prod_s1));
				OP_MPX: wps_q[0] <= add_ssat(wps_q[0], sterm(sp_q[0], prod_s1));
				OP_MPY: wps_q[1] <= add_ssat(wps_q[1], sterm(sp_q[1], prod_s1));
				OP_MPZ: wps_q[2] <= add_ssat(wps_q[2], sterm(sp_q[2], prod_s1));
				default: ;
			endcase

			if (v_s2) begin
				case (tgt_s2)
					TGT_KIN:   kin_q <= add_usat(kin_q, wt_s2);
					TGT_THERM: therm_q <= add_usat(therm_q, wt_s2);
					default: ;
				endcase
			end

			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
				count_q     <= '0;
				mass_sum_q  <= '0;
				kin_q       <= '0;
				therm_q     <= '0;
				ovf_q       <= 1'b0;
				for (int k = 0; k < 3; k++) begin
					mom_q[k] <= '0;
					wps_q[k] <= '0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// operands, products and division results
	always_ff @(posedge clk) begin
		prod_s1 <= mul_p;

		if (cmd.take && !stat.full) begin
			m_q     <= m_in;
			av_q[0] <= mag33({in_data.vel_x[31], in_data.vel_x});
			av_q[1] <= mag33({in_data.vel_y[31], in_data.vel_y});
			av_q[2] <= mag33({in_data.vel_z[31], in_data.vel_z});
			sv_q[0] <= in_data.vel_x[31];
			sv_q[1] <= in_data.vel_y[31];
			sv_q[2] <= in_data.vel_z[31];
			ap_q[0] <= mag33({in_data.pos_x[31], in_data.pos_x});
			ap_q[1] <= mag33({in_data.pos_y[31], in_data.pos_y});
			ap_q[2] <= mag33({in_data.pos_z[31], in_data.pos_z});
			sp_q[0] <= in_data.pos_x[31];
			sp_q[1] <= in_data.pos_y[31];
			sp_q[2] <= in_data.pos_z[31];
		end else if (cmd.op == OP_LD) begin
			// deviation from center-of-mass velocity
			m_q     <= mass_of(mass_cfg, dout_q.ptype);
			av_q[0] <= mag33({dout_q.vx[31], dout_q.vx} - {vcm_q[0][31], vcm_q[0]});
			av_q[1] <= mag33({dout_q.vy[31], dout_q.vy} - {vcm_q[1][31], vcm_q[1]});
			av_q[2] <= mag33({dout_q.vz[31], dout_q.vz} - {vcm_q[2][31], vcm_q[2]});
		end

		if (cmd.take || cmd.op == OP_LD)
			s_q <= '0;
		else if (op_s1 inside {OP_VX2, OP_VY2, OP_VZ2, OP_DX2, OP_DY2, OP_DZ2})
			s_q <= s_q + prod_s1[65:0];

		if (op_s1 inside {OP_KLO, OP_TLO, OP_QLO})
			w_q <= prod_s1;

		wt_s2 <= wt_next;
		case (op_s1)
			OP_KHI:  tgt_s2 <= TGT_KIN;
			OP_THI:  tgt_s2 <= TGT_THERM;
			default: tgt_s2 <= TGT_TEMP;
		endcase
		if (v_s2 && tgt_s2 == TGT_TEMP)
			temp_q <= wt_s2[63] ? {63{1'b1}} : wt_s2[62:0];

		if (cmd.div_start) begin
			dsel_q  <= cmd.div_sel;
			dsign_q <= div_sign;
		end
		if (div_done) begin
			case (dsel_q)
				DIV_COM_X: com_q[0] <= div_res;
				DIV_COM_Y: com_q[1] <= div_res;
				DIV_COM_Z: com_q[2] <= div_res;
				DIV_VCM_X: vcm_q[0] <= div_res;
				DIV_VCM_Y: vcm_q[1] <= div_res;
				DIV_VCM_Z: vcm_q[2] <= div_res;
				default:   tq_q <= div_q;
			endcase
		end

		if (cmd.res_load)
			res_q <= res_next;
	end

	assign stat.full      = (count_q == CNT_W'(MAX_PARTICLES));
	assign stat.mass_zero = (mass_sum_q == '0);
	assign stat.div_done  = div_done;
	assign stat.idx_end   = (idx_q == count_q);
	assign stat.slot_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = res_q;

endmodule

// ----- rtl/md_energy_momentum_reduction_unit.sv -----
// Energy and momentum reduction over a set of particles. Each transfer on the
// input channel carries one particle (type, Q16.16 position and velocity);
// the mass comes from the register for its type, with type 3 taking the noble
// gas mass. A kept particle is worked through before the next one can be
// taken: one shared 33x35 multiplier works through eleven products (three
// squares, six mass products, two partial products for the kinetic term),
// then its pipeline drains. Velocities and types go into a 1024 entry store;
// a particle arriving with the store full is dropped and flags overflow. On
// the particle marked last the block runs six divisions of 64 quotient bits
// each for center of mass and center-of-mass velocity, a second pass over
// the stored particles for the thermal sum, one more division by the
// particle count, and the temperature scaling; a zero total mass skips these
// and flags a zero-mass error. The result then waits in an output register,
// and new particles are taken while it waits. Mass registers sit at byte
// addresses 0, 4 and 8 of the APB-style port and must only be written while
// the block is idle.
module md_energy_momentum_reduction_unit import md_emr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  particle_t   in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	mass_cfg_t mass_q;
	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	logic      cfg_wr;

	// zero-wait-state register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_MASS_NITROGEN:  mass_q.mass_nitrogen  <= pwdata;
				REG_MASS_OXYGEN:    mass_q.mass_oxygen    <= pwdata;
				REG_MASS_NOBLE_GAS: mass_q.mass_noble_gas <= pwdata;
				default: ; // drop writes past the last register
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MASS_NITROGEN:  prdata = mass_q.mass_nitrogen;
			REG_MASS_OXYGEN:    prdata = mass_q.mass_oxygen;
			REG_MASS_NOBLE_GAS: prdata = mass_q.mass_noble_gas;
			default:            prdata = '0;
		endcase
	end

	// sequence the passes
	md_emr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (in_data.last),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// sums, store, multiplier, divider and result register
	md_emr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.mass_cfg  (mass_q),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

// ----- tb/tb_md_energy_momentum_reduction_unit.sv -----
`timescale 1ns / 100ps

module tb_md_energy_momentum_reduction_unit import md_emr_pkg::*; ();

	// Types 2 and 3 both take the noble gas mass.
	localparam logic [1:0] TYPE_NOBLE   = 2'd2;
	localparam logic [1:0] TYPE_UNKNOWN = 2'd3;
	localparam int CYCLE_LIMIT = 2_000_000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	particle_t   in_data;
	logic        out_valid;
	logic        out_ready;
	result_t     out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	md_energy_momentum_reduction_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Shadow copy of the mass registers and the accumulator state.
	logic [31:0]        mass_reg [3];
	logic signed [31:0] shadow_vx [MAX_PARTICLES];
	logic signed [31:0] shadow_vy [MAX_PARTICLES];
	logic signed [31:0] shadow_vz [MAX_PARTICLES];
	logic [1:0]         shadow_type [MAX_PARTICLES];
	int unsigned        kept_count;
	logic [63:0]        mass_total;
	logic [63:0]        kinetic_total;
	logic signed [63:0] momentum_total [3];
	logic signed [63:0] position_total [3];
	logic               dropped_any;

	particle_t   particle_queue[$];
	result_t     result_queue[$];
	int unsigned fail_count;
	int unsigned particles_taken;
	int unsigned results_seen;
	int unsigned sets_sent;
	int unsigned cycle_count;

	task automatic queue_particle(input particle_t p);
		particle_queue.insert(particle_queue.size(), p);
	endtask

	task automatic queue_result(input result_t r);
		result_queue.insert(result_queue.size(), r);
	endtask

	function automatic logic [31:0] mass_for(input logic [1:0] t);
		case (t)
			TYPE_NITROGEN: return mass_reg[0];
			TYPE_OXYGEN:   return mass_reg[1];
			default:       return mass_reg[2];
		endcase
	endfunction

	function automatic logic [63:0] magnitude(input logic signed [63:0] v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] add_signed_sat(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s[63:0];
	endfunction

	function automatic logic [63:0] add_unsigned_sat(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic logic [63:0] shift16_sat(input logic [127:0] w);
		return (|w[127:80]) ? '1 : w[79:16];
	endfunction

	function automatic logic signed [63:0] mass_times(input logic [31:0] m,
			input logic signed [63:0] v);
		logic [63:0] p;
		p = 64'(m) * magnitude(v);
		return v < 0 ? -$signed(p) : $signed(p);
	endfunction

	function automatic logic signed [31:0] quotient_sat(input logic signed [63:0] s,
			input logic [63:0] d);
		logic [63:0] q;
		q = magnitude(s) / d;
		if (s < 0)
			return q > 64'h8000_0000 ? 32'sh8000_0000 : 32'(-$signed(q));
		return q > 64'h7FFF_FFFF ? 32'sh7FFF_FFFF : 32'(q);
	endfunction

	task automatic clear_totals();
		kept_count = 0;
		mass_total = '0;
		kinetic_total = '0;
		dropped_any = 1'b0;
		for (int k = 0; k < 3; k++) begin
			momentum_total[k] = '0;
			position_total[k] = '0;
		end
	endtask

	// Fold one accepted particle into the totals; on the last one of a set,
	// work out the reduction and queue it.
	task automatic absorb_particle(input particle_t p);
		logic signed [63:0] pos [3];
		logic signed [63:0] vel [3];
		logic signed [63:0] vcm [3];
		logic signed [63:0] d;
		logic [63:0]        sq;
		logic [63:0]        a;
		logic [127:0]       s;
		logic [63:0]        thermal;
		logic [63:0]        scaled;
		logic [31:0]        m;
		result_t            r;
		pos[0] = p.pos_x; pos[1] = p.pos_y; pos[2] = p.pos_z;
		vel[0] = p.vel_x; vel[1] = p.vel_y; vel[2] = p.vel_z;
		if (kept_count >= MAX_PARTICLES) begin
			dropped_any = 1'b1;
		end else begin
			m = mass_for(p.particle_type);
			sq = '0;
			for (int k = 0; k < 3; k++) begin
				a = magnitude(vel[k]);
				sq += a * a;
				momentum_total[k] = add_signed_sat(momentum_total[k], mass_times(m, vel[k]));
				position_total[k] = add_signed_sat(position_total[k], mass_times(m, pos[k]));
			end
			kinetic_total = add_unsigned_sat(kinetic_total,
				shift16_sat(128'(m) * 128'(sq)));
			mass_total += 64'(m);
			shadow_vx[kept_count] = p.vel_x;
			shadow_vy[kept_count] = p.vel_y;
			shadow_vz[kept_count] = p.vel_z;
			shadow_type[kept_count] = p.particle_type;
			kept_count++;
		end
		if (!p.last)
			return;
		r = '0;
		r.overflow = dropped_any;
		if (mass_total == 0 || kept_count == 0) begin
			r.zero_mass_error = 1'b1;
		end else begin
			r.com_x = quotient_sat(position_total[0], mass_total);
			r.com_y = quotient_sat(position_total[1], mass_total);
			r.com_z = quotient_sat(position_total[2], mass_total);
			r.momentum_x = momentum_total[0];
			r.momentum_y = momentum_total[1];
			r.momentum_z = momentum_total[2];
			r.kinetic_energy = kinetic_total[63:1];
			for (int k = 0; k < 3; k++)
				vcm[k] = quotient_sat(momentum_total[k], mass_total);
			// Second pass uses the masses in force now, not at arrival.
			thermal = '0;
			for (int i = 0; i < kept_count; i++) begin
				s = '0;
				d = 64'(shadow_vx[i]) - vcm[0];
				a = magnitude(d);
				s += 128'(a) * 128'(a);
				d = 64'(shadow_vy[i]) - vcm[1];
				a = magnitude(d);
				s += 128'(a) * 128'(a);
				d = 64'(shadow_vz[i]) - vcm[2];
				a = magnitude(d);
				s += 128'(a) * 128'(a);
				thermal = add_unsigned_sat(thermal,
					shift16_sat(s * 128'(mass_for(shadow_type[i]))));
			end
			scaled = shift16_sat(128'(thermal / 64'(kept_count)) * 128'(TEMP_SCALE));
			r.temperature = scaled[63] ? {63{1'b1}} : scaled[62:0];
		end
		queue_result(r);
		clear_totals();
	endtask

	// Random idles on either side, apart from a steady stretch with no idling.
	function automatic logic take_a_break();
		if (cycle_count % 40000 < 6000)
			return 1'b0;
		return $urandom_range(99) < 25;
	endfunction

	// Driver: present the next particle, advance on each transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready) begin
				absorb_particle(in_data);
				particles_taken++;
			end
			if (!in_valid || in_ready) begin
				if (particle_queue.size() > 0 && !take_a_break()) begin
					in_valid <= 1'b1;
					in_data <= particle_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result transfer with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (result_queue.size() == 0) begin
					$error("result with nothing predicted");
					fail_count++;
				end else begin
					want = result_queue.pop_front();
					if (out_data.com_x !== want.com_x) begin
						$error("com_x exp %h got %h", want.com_x, out_data.com_x);
						fail_count++;
					end
					if (out_data.com_y !== want.com_y) begin
						$error("com_y exp %h got %h", want.com_y, out_data.com_y);
						fail_count++;
					end
					if (out_data.com_z !== want.com_z) begin
						$error("com_z exp %h got %h", want.com_z, out_data.com_z);
						fail_count++;
					end
					if (out_data.kinetic_energy !== want.kinetic_energy) begin
						$error("kinetic_energy exp %h got %h", want.kinetic_energy,
							out_data.kinetic_energy);
						fail_count++;
					end
					if (out_data.momentum_x !== want.momentum_x) begin
						$error("momentum_x exp %h got %h", want.momentum_x, out_data.momentum_x);
						fail_count++;
					end
					if (out_data.momentum_y !== want.momentum_y) begin
						$error("momentum_y exp %h got %h", want.momentum_y, out_data.momentum_y);
						fail_count++;
					end
					if (out_data.momentum_z !== want.momentum_z) begin
						$error("momentum_z exp %h got %h", want.momentum_z, out_data.momentum_z);
						fail_count++;
					end
					if (out_data.temperature !== want.temperature) begin
						$error("temperature exp %h got %h", want.temperature,
							out_data.temperature);
						fail_count++;
					end
					if (out_data.zero_mass_error !== want.zero_mass_error) begin
						$error("zero_mass_error exp %b got %b", want.zero_mass_error,
							out_data.zero_mass_error);
						fail_count++;
					end
					if (out_data.overflow !== want.overflow) begin
						$error("overflow exp %b got %b", want.overflow, out_data.overflow);
						fail_count++;
					end
				end
			end
			out_ready <= !take_a_break();
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Mostly small values so temperatures stay in range; extremes now and then.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0, 1:    return $urandom;
			2:       return 32'h8000_0000;
			3:       return 32'h7FFF_FFFF;
			default: return 32'($signed($urandom_range(2_000_000)) - 1_000_000);
		endcase
	endfunction

	function automatic particle_t make_particle(input logic [1:0] t, input logic [31:0] v,
			input logic is_last);
		particle_t p;
		p.particle_type = t;
		p.pos_x = v; p.pos_y = v; p.pos_z = v;
		p.vel_x = v; p.vel_y = v; p.vel_z = v;
		p.last = is_last;
		return p;
	endfunction

	task automatic random_set(input int n);
		particle_t p;
		for (int i = 0; i < n; i++) begin
			p.particle_type = 2'($urandom_range(3));
			p.pos_x = pick_value(); p.pos_y = pick_value(); p.pos_z = pick_value();
			p.vel_x = pick_value(); p.vel_y = pick_value(); p.vel_z = pick_value();
			p.last = (i == n - 1);
			queue_particle(p);
		end
		sets_sent++;
	endtask

	// Hold until every particle is taken and every result is back, then let
	// the block settle.
	task automatic drain();
		do @(posedge clk);
		while (particle_queue.size() > 0 || in_valid || result_queue.size() > 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_mass(input logic [1:0] index, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		mass_reg[index] = value;
	endtask

	task automatic write_masses(input logic [31:0] mn, input logic [31:0] mo,
			input logic [31:0] mg);
		write_mass(REG_MASS_NITROGEN, mn);
		write_mass(REG_MASS_OXYGEN, mo);
		write_mass(REG_MASS_NOBLE_GAS, mg);
	endtask

	initial begin
		int budget;
		int n;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fail_count = 0;
		particles_taken = 0;
		results_seen = 0;
		sets_sent = 0;
		cycle_count = 0;
		for (int k = 0; k < 3; k++)
			mass_reg[k] = '0;
		clear_totals();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Masses still at reset: zero total mass.
		queue_particle(make_particle(TYPE_NITROGEN, 32'h0001_0000, 1'b0));
		queue_particle(make_particle(TYPE_UNKNOWN, 32'hFFFF_0000, 1'b1));
		sets_sent++;
		drain();

		// Full-scale masses with extreme positions and velocities: saturation.
		write_masses('1, '1, '1);
		queue_particle(make_particle(TYPE_NITROGEN, 32'h8000_0000, 1'b0));
		queue_particle(make_particle(TYPE_OXYGEN, 32'h8000_0000, 1'b0));
		queue_particle(make_particle(TYPE_NOBLE, 32'h8000_0000, 1'b1));
		queue_particle(make_particle(TYPE_UNKNOWN, 32'h7FFF_FFFF, 1'b0));
		queue_particle(make_particle(TYPE_NITROGEN, 32'h7FFF_FFFF, 1'b0));
		queue_particle(make_particle(TYPE_OXYGEN, 32'h8000_0000, 1'b1));
		queue_particle(make_particle(TYPE_NOBLE, 32'h0000_0000, 1'b1));
		sets_sent += 3;
		drain();

		// Only one type weighed: others contribute nothing; type 3 as noble gas.
		write_masses(32'd0, 32'd0, 32'h0002_8000);
		queue_particle(make_particle(TYPE_NITROGEN, 32'h0003_0000, 1'b1));
		queue_particle(make_particle(TYPE_OXYGEN, 32'hFFFD_0000, 1'b0));
		queue_particle(make_particle(TYPE_UNKNOWN, 32'h0001_2345, 1'b0));
		queue_particle(make_particle(TYPE_NOBLE, 32'hFFFF_8000, 1'b1));
		sets_sent += 2;
		drain();

		// Overflow: more particles than the store holds, last three dropped.
		write_masses(32'h000E_0000, 32'h0010_0000, 32'h0028_0000);
		random_set(MAX_PARTICLES + 3);
		drain();

		// Random sets under changing masses.
		budget = 800;
		while (budget > 0) begin
			case ($urandom_range(4))
				0: write_masses($urandom, $urandom, $urandom);
				1: write_masses(32'd1, 32'd0, '1);
				default: write_masses($urandom_range(32'h0040_0000),
					$urandom_range(32'h0040_0000), $urandom_range(32'h0040_0000));
			endcase
			for (int s = 0; s < 20 && budget > 0; s++) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
				random_set(n);
				budget -= n;
			end
			drain();
		end

		repeat (100) @(posedge clk);
		if (result_queue.size() != 0) begin
			$error("%0d predicted results never arrived", result_queue.size());
			fail_count++;
		end
		$display("Covered %0d particle transfers in %0d sets, %0d results checked,",
			particles_taken, sets_sent, results_seen);
		$display("including zero-mass, saturation, unknown-type and store-overflow sets.");
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/md_emr_pkg.sv
rtl/md_emr_div.sv
rtl/md_emr_ctrl.sv
rtl/md_emr_dp.sv
rtl/md_energy_momentum_reduction_unit.sv
tb/tb_md_energy_momentum_reduction_unit.sv
